FILE: design/button_debounce_event_gen_unit_assert.svh
// Assertion macros shared by the debounce block.
`ifndef BUTTON_DEBOUNCE_EVENT_GEN_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_EVENT_GEN_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property while out of reset.
`define BDE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
// Check a property at every edge, reset included.
`define BDE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define BDE_ASSERT(lbl, clk, rst_n, prop)
`define BDE_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/bde_pkg.sv
package bde_pkg;

    localparam int NumButtonsDefault = 4;
    localparam int MaskBits          = 4;
    localparam int BtnIdxW           = 2;
    localparam int TimeW             = 32;
    localparam int CfgW              = 16;
    localparam int CfgAddrW          = 2;
    localparam int FifoDepth         = 4;
    localparam int STdataW           = 40;
    localparam int MTdataW           = 40;

    localparam logic [CfgW-1:0] DebounceReset   = 16'd25;
    localparam logic [CfgW-1:0] LongPressReset  = 16'd700;
    localparam logic [CfgW-1:0] RepeatDlyReset  = 16'd900;
    localparam logic [CfgW-1:0] RepeatPerReset  = 16'd175;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_LONG    = 2'd2,
        EV_REPEAT  = 2'd3
    } ev_kind_t;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT_DLY = 2'd2,
        CFG_REPEAT_PER = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_EVAL,
        FR_EMIT,
        FR_FLUSH
    } front_state_t;

    typedef struct packed {
        logic [CfgW-1:0] debounce_time;
        logic [CfgW-1:0] long_press_time;
        logic [CfgW-1:0] repeat_delay;
        logic [CfgW-1:0] repeat_period;
    } cfg_t;

    typedef struct packed {
        logic [BtnIdxW-1:0] button_index;
        ev_kind_t           event_kind;
        logic [TimeW-1:0]   event_time;
        logic               last_event;
    } ev_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

FILE: design/bde_front.sv
module bde_front #(
    parameter int NUM_BUTTONS = bde_pkg::NumButtonsDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bde_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bde_pkg::MaskBits-1:0] s_raw_mask,
    input  logic [bde_pkg::TimeW-1:0]    s_now_time,
    input  logic                         fifo_full,
    output logic                         push,
    output bde_pkg::ev_entry_t           push_entry
);

    localparam int BtnW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [BtnW-1:0] LastBtn = BtnW'(NUM_BUTTONS - 1);

    bde_pkg::front_state_t state_reg, state_next;
    logic [BtnW-1:0]              btn_reg, btn_next;
    logic [bde_pkg::MaskBits-1:0] mask_reg, mask_next;
    logic [bde_pkg::TimeW-1:0]    now_reg, now_next;
    logic [3:0]                   flags_reg, flags_next;
    logic                         pend_valid_reg, pend_valid_next;
    bde_pkg::ev_entry_t           pend_reg, pend_next;

    logic                         raw_level_reg    [NUM_BUTTONS];
    logic                         stable_level_reg [NUM_BUTTONS];
    logic                         long_done_reg    [NUM_BUTTONS];
    logic [bde_pkg::TimeW-1:0]    change_time_reg  [NUM_BUTTONS];
    logic [bde_pkg::TimeW-1:0]    press_time_reg   [NUM_BUTTONS];
    logic [bde_pkg::TimeW-1:0]    repeat_due_reg   [NUM_BUTTONS];

    // per-button evaluation
    logic                      eval_we;
    logic                      raw_cur, raw_chg, commit, commit_press, held;
    logic                      stable_new, long_old_eff, long_fire, rep_fire, long_new;
    logic [bde_pkg::TimeW-1:0] chg_eff, deb_diff, press_eff, press_diff;
    logic [bde_pkg::TimeW-1:0] rep_diff, due_base, due_add, due_new;
    bde_pkg::ev_kind_t         kind_sel;

    always_comb begin
        raw_cur = 1'b0;
        if (32'(btn_reg) < bde_pkg::MaskBits) begin
            raw_cur = mask_reg[2'(btn_reg)];
        end
        raw_chg  = raw_cur != raw_level_reg[btn_reg];
        chg_eff  = raw_chg ? now_reg : change_time_reg[btn_reg];
        deb_diff = now_reg - chg_eff;
        commit   = (raw_cur != stable_level_reg[btn_reg]) &&
                   (deb_diff >= {16'd0, cfg.debounce_time});
        commit_press = commit && raw_cur;
        stable_new   = commit ? raw_cur : stable_level_reg[btn_reg];
        held         = stable_new && raw_cur;

        press_eff    = commit_press ? now_reg : press_time_reg[btn_reg];
        press_diff   = now_reg - press_eff;
        long_old_eff = commit ? 1'b0 : long_done_reg[btn_reg];
        long_fire    = held && !long_old_eff &&
                       (press_diff >= {16'd0, cfg.long_press_time});
        long_new     = long_old_eff || long_fire;

        // a fresh press puts the first repeat at now + delay, due at once only for zero delay
        rep_diff = now_reg - repeat_due_reg[btn_reg];
        rep_fire = held && (commit_press ? (cfg.repeat_delay == '0) : !rep_diff[31]);
        due_base = commit_press ? now_reg : repeat_due_reg[btn_reg];
        if (rep_fire) begin
            due_add = {16'd0, cfg.repeat_period};
        end else if (commit_press) begin
            due_add = {16'd0, cfg.repeat_delay};
        end else begin
            due_add = '0;
        end
        due_new = due_base + due_add;
    end

    always_comb begin
        priority if (flags_reg[0]) begin
            kind_sel = bde_pkg::EV_PRESS;
        end else if (flags_reg[1]) begin
            kind_sel = bde_pkg::EV_RELEASE;
        end else if (flags_reg[2]) begin
            kind_sel = bde_pkg::EV_LONG;
        end else begin
            kind_sel = bde_pkg::EV_REPEAT;
        end
    end

    always_comb begin
        state_next      = state_reg;
        btn_next        = btn_reg;
        mask_next       = mask_reg;
        now_next        = now_reg;
        flags_next      = flags_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        s_tready        = 1'b0;
        eval_we         = 1'b0;
        push            = 1'b0;
        push_entry      = pend_reg;
        push_entry.last_event = 1'b0;

        unique case (state_reg)
            bde_pkg::FR_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mask_next  = s_raw_mask;
                    now_next   = s_now_time;
                    btn_next   = '0;
                    state_next = bde_pkg::FR_EVAL;
                end
            end
            bde_pkg::FR_EVAL: begin
                eval_we    = 1'b1;
                flags_next = {rep_fire, long_fire, commit && !raw_cur, commit_press};
                state_next = bde_pkg::FR_EMIT;
            end
            bde_pkg::FR_EMIT: begin
                if (flags_reg != '0) begin
                    // hold the newest request back until we know whether it ends the scan
                    if (!pend_valid_reg || !fifo_full) begin
                        push                    = pend_valid_reg;
                        pend_valid_next         = 1'b1;
                        pend_next.button_index  = 2'(btn_reg);
                        pend_next.event_kind    = kind_sel;
                        pend_next.event_time    = now_reg;
                        pend_next.last_event    = 1'b0;
                        flags_next = flags_reg & ~(4'd1 << kind_sel);
                    end
                end else if (btn_reg == LastBtn) begin
                    state_next = bde_pkg::FR_FLUSH;
                end else begin
                    btn_next   = btn_reg + 1'b1;
                    state_next = bde_pkg::FR_EVAL;
                end
            end
            bde_pkg::FR_FLUSH: begin
                push_entry.last_event = 1'b1;
                if (!pend_valid_reg) begin
                    state_next = bde_pkg::FR_IDLE;
                end else if (!fifo_full) begin
                    push            = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = bde_pkg::FR_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bde_pkg::FR_IDLE;
            pend_valid_reg <= 1'b0;
            flags_reg      <= '0;
            btn_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            flags_reg      <= flags_next;
            btn_reg        <= btn_next;
        end
        mask_reg <= mask_next;
        now_reg  <= now_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                raw_level_reg[i]    <= 1'b0;
                stable_level_reg[i] <= 1'b0;
                long_done_reg[i]    <= 1'b0;
                change_time_reg[i]  <= '0;
                press_time_reg[i]   <= '0;
                repeat_due_reg[i]   <= '0;
            end
        end else if (eval_we) begin
            raw_level_reg[btn_reg]    <= raw_cur;
            stable_level_reg[btn_reg] <= stable_new;
            long_done_reg[btn_reg]    <= long_new;
            change_time_reg[btn_reg]  <= chg_eff;
            press_time_reg[btn_reg]   <= press_eff;
            repeat_due_reg[btn_reg]   <= due_new;
        end
    end

endmodule

FILE: design/bde_fifo.sv
module bde_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bde_pkg::ev_entry_t  push_data,
    input  logic                pop,
    output bde_pkg::ev_entry_t  rd_data,
    output bde_pkg::fifo_stat_t stat
);

    localparam int PtrW = $clog2(bde_pkg::FifoDepth);
    localparam int CntW = PtrW + 1;

    bde_pkg::ev_entry_t entry_reg [bde_pkg::FifoDepth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CntW'(push) - CntW'(pop);
        stat.full   = count_reg == CntW'(bde_pkg::FifoDepth);
        stat.empty  = count_reg == '0;
        rd_data     = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/bde_back.sv
module bde_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bde_pkg::ev_entry_t            rd_data,
    input  bde_pkg::fifo_stat_t           stat,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bde_pkg::MTdataW-1:0]   m_tdata,
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam int PadW = bde_pkg::MTdataW - bde_pkg::TimeW - bde_pkg::BtnIdxW;

    logic                          valid_reg, valid_next;
    logic [bde_pkg::MTdataW-1:0]   data_reg, data_next;
    logic [1:0]                    user_reg, user_next;
    logic                          last_reg, last_next;

    always_comb begin
        pop        = !stat.empty && (!valid_reg || m_tready);
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (pop) begin
            valid_next = 1'b1;
            data_next  = {PadW'(0), rd_data.event_time, rd_data.button_index};
            user_next  = rd_data.event_kind;
            last_next  = rd_data.last_event;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: design/button_debounce_event_gen_unit.sv
// Button debounce and event generator, one scan at a time.
// The front sequencer evaluates one button, then emits its events (0..3 per button) one per
// cycle unless the queue is full, and then moves on to the next button. Events pass a
// 4-deep queue and one output register.
// Reset: synchronous active-low aresetn restores register defaults and clears all button state.
`include "button_debounce_event_gen_unit_assert.svh"

module button_debounce_event_gen_unit #(
    parameter int NUM_BUTTONS = bde_pkg::NumButtonsDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bde_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bde_pkg::CfgW-1:0]      cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bde_pkg::STdataW-1:0]   s_tdata,  // raw_mask[3:0], now_time[35:4], zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bde_pkg::MTdataW-1:0]   m_tdata,  // button_index[1:0], event_time[33:2], pad
    output logic [1:0]                    m_tuser,  // event_kind[1:0]
    output logic                          m_tlast
);

    bde_pkg::cfg_t       cfg_reg, cfg_next;
    logic                fifo_push, fifo_pop;
    bde_pkg::ev_entry_t  push_entry, rd_entry;
    bde_pkg::fifo_stat_t fifo_stat;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                bde_pkg::CFG_DEBOUNCE:   cfg_next.debounce_time   = cfg_wr_data;
                bde_pkg::CFG_LONG_PRESS: cfg_next.long_press_time = cfg_wr_data;
                bde_pkg::CFG_REPEAT_DLY: cfg_next.repeat_delay    = cfg_wr_data;
                bde_pkg::CFG_REPEAT_PER: cfg_next.repeat_period   = cfg_wr_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time   <= bde_pkg::DebounceReset;
            cfg_reg.long_press_time <= bde_pkg::LongPressReset;
            cfg_reg.repeat_delay    <= bde_pkg::RepeatDlyReset;
            cfg_reg.repeat_period   <= bde_pkg::RepeatPerReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bde_front #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_raw_mask (s_tdata[bde_pkg::MaskBits-1:0]),
        .s_now_time (s_tdata[bde_pkg::MaskBits +: bde_pkg::TimeW]),
        .fifo_full  (fifo_stat.full),
        .push       (fifo_push),
        .push_entry (push_entry)
    );

    bde_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_entry),
        .pop       (fifo_pop),
        .rd_data   (rd_entry),
        .stat      (fifo_stat)
    );

    bde_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_data  (rd_entry),
        .stat     (fifo_stat),
        .pop      (fifo_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `BDE_ASSERT(a_push_has_room, aclk, aresetn, fifo_push |-> !fifo_stat.full)
    `BDE_ASSERT(a_pop_has_data, aclk, aresetn, fifo_pop |-> !fifo_stat.empty)
    `BDE_ASSERT(a_scan_blocks_input, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)

endmodule

FILE: verif/button_debounce_event_gen_unit_test.sv
module button_debounce_event_gen_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumButtons   = bde_pkg::NumButtonsDefault;
    localparam int SettleCycles = 40;
    localparam int CycleLimit   = 2_000_000;

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    bde_pkg::cfg_idx_t             cfg_addr    = bde_pkg::CFG_DEBOUNCE;
    logic [bde_pkg::CfgW-1:0]      cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [bde_pkg::STdataW-1:0]   s_tdata     = '0;  // raw_mask[3:0], now_time[35:4], zero pad
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [bde_pkg::MTdataW-1:0]   m_tdata;           // button_index[1:0], event_time[33:2], pad
    logic [1:0]                    m_tuser;           // event_kind[1:0]
    logic                          m_tlast;

    // timing registers as the block should hold them
    logic [bde_pkg::CfgW-1:0]      deb_time_cfg;
    logic [bde_pkg::CfgW-1:0]      long_time_cfg;
    logic [bde_pkg::CfgW-1:0]      rpt_delay_cfg;
    logic [bde_pkg::CfgW-1:0]      rpt_period_cfg;

    // per-button tracking
    logic                          btn_raw    [NumButtons];
    logic                          btn_stable [NumButtons];
    logic                          btn_long   [NumButtons];
    logic [bde_pkg::TimeW-1:0]     t_change   [NumButtons];
    logic [bde_pkg::TimeW-1:0]     t_press    [NumButtons];
    logic [bde_pkg::TimeW-1:0]     t_repeat   [NumButtons];

    bde_pkg::ev_entry_t            pending_events[$];
    bde_pkg::ev_entry_t            seen_event;
    bde_pkg::ev_entry_t            want_event;

    logic [bde_pkg::TimeW-1:0]     clock_ms;
    logic [bde_pkg::MaskBits-1:0]  held_mask;
    bit                            stall_enable = 1'b1;
    int                            ready_hold   = 0;
    int                            fail_count   = 0;
    int                            scans_sent   = 0;
    int                            events_seen  = 0;
    int                            settings_loaded = 0;
    int                            cycle_count  = 0;

    button_debounce_event_gen_unit #(
        .NUM_BUTTONS(NumButtons)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Receiver stalls: mostly short, now and then a long one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!stall_enable || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end
    end

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_event.button_index = m_tdata[bde_pkg::BtnIdxW-1:0];
            seen_event.event_kind   = bde_pkg::ev_kind_t'(m_tuser);
            seen_event.event_time   = m_tdata[bde_pkg::BtnIdxW+bde_pkg::TimeW-1:bde_pkg::BtnIdxW];
            seen_event.last_event   = m_tlast;
            events_seen++;
            if (pending_events.size() == 0) begin
                log_failure($sformatf("Unexpected event: button %0d kind %0d time %h last %b",
                                      seen_event.button_index, seen_event.event_kind,
                                      seen_event.event_time, seen_event.last_event));
            end else begin
                want_event = pending_events.pop_front();
                if (seen_event.button_index !== want_event.button_index ||
                    seen_event.event_kind   !== want_event.event_kind   ||
                    seen_event.event_time   !== want_event.event_time   ||
                    seen_event.last_event   !== want_event.last_event) begin
                    log_failure($sformatf(
                        "Mismatch: button %0d/%0d kind %0d/%0d time %h/%h last %b/%b (exp/act)",
                        want_event.button_index, seen_event.button_index,
                        want_event.event_kind, seen_event.event_kind,
                        want_event.event_time, seen_event.event_time,
                        want_event.last_event, seen_event.last_event));
                end
            end
        end
    end

    function automatic bde_pkg::ev_entry_t make_event(input int b,
                                                      input bde_pkg::ev_kind_t kind,
                                                      input logic [bde_pkg::TimeW-1:0] now);
        bde_pkg::ev_entry_t e;
        e.button_index = b[bde_pkg::BtnIdxW-1:0];
        e.event_kind   = kind;
        e.event_time   = now;
        e.last_event   = 1'b0;
        return e;
    endfunction

    task automatic predict_scan_events(input logic [bde_pkg::MaskBits-1:0] mask,
                                       input logic [bde_pkg::TimeW-1:0] now);
        bde_pkg::ev_entry_t        found[$];
        bde_pkg::ev_entry_t        tail;
        logic [bde_pkg::TimeW-1:0] held;
        for (int b = 0; b < NumButtons; b++) begin
            if (mask[b] != btn_raw[b]) begin
                btn_raw[b]  = mask[b];
                t_change[b] = now;
            end
            held = now - t_change[b];
            if (btn_raw[b] != btn_stable[b] && held >= {16'd0, deb_time_cfg}) begin
                btn_stable[b] = btn_raw[b];
                btn_long[b]   = 1'b0;
                if (btn_stable[b]) begin
                    t_press[b]  = now;
                    t_repeat[b] = now + {16'd0, rpt_delay_cfg};
                    found.push_back(make_event(b, bde_pkg::EV_PRESS, now));
                end else begin
                    found.push_back(make_event(b, bde_pkg::EV_RELEASE, now));
                end
            end
            if (btn_stable[b] && btn_raw[b]) begin
                held = now - t_press[b];
                if (!btn_long[b] && held >= {16'd0, long_time_cfg}) begin
                    btn_long[b] = 1'b1;
                    found.push_back(make_event(b, bde_pkg::EV_LONG, now));
                end
                // due while the wrapped distance past the deadline is below half range
                held = now - t_repeat[b];
                if (!held[bde_pkg::TimeW-1]) begin
                    found.push_back(make_event(b, bde_pkg::EV_REPEAT, now));
                    t_repeat[b] = t_repeat[b] + {16'd0, rpt_period_cfg};
                end
            end
        end
        if (found.size() > 0) begin
            tail = found.pop_back();
            tail.last_event = 1'b1;
            found.push_back(tail);
        end
        foreach (found[k]) pending_events.push_back(found[k]);
    endtask

    function automatic int pick_gap();
        int r;
        if (!stall_enable) begin
            return 0;
        end
        r = $urandom_range(0, 19);
        if (r < 10) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_scan(input logic [bde_pkg::MaskBits-1:0] mask,
                             input logic [bde_pkg::TimeW-1:0] now);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bde_pkg::STdataW-bde_pkg::MaskBits-bde_pkg::TimeW){1'b0}}, now, mask};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_scan_events(mask, now);
        scans_sent++;
    endtask

    // Drop the request and let the block finish every scan it holds.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic load_timing(input logic [bde_pkg::CfgW-1:0] deb,
                               input logic [bde_pkg::CfgW-1:0] lp,
                               input logic [bde_pkg::CfgW-1:0] rd,
                               input logic [bde_pkg::CfgW-1:0] rp);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= bde_pkg::CFG_DEBOUNCE;
        cfg_wr_data <= deb;
        @(posedge aclk);
        cfg_addr    <= bde_pkg::CFG_LONG_PRESS;
        cfg_wr_data <= lp;
        @(posedge aclk);
        cfg_addr    <= bde_pkg::CFG_REPEAT_DLY;
        cfg_wr_data <= rd;
        @(posedge aclk);
        cfg_addr    <= bde_pkg::CFG_REPEAT_PER;
        cfg_wr_data <= rp;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        deb_time_cfg   = deb;
        long_time_cfg  = lp;
        rpt_delay_cfg  = rd;
        rpt_period_cfg = rp;
        settings_loaded++;
    endtask

    task automatic run_random_scans(input int count, input int step_max, input int flip_odds,
                                    input int pause_at);
        int r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 5) begin
                held_mask = bde_pkg::MaskBits'($urandom_range(0, 15));
            end else begin
                for (int b = 0; b < bde_pkg::MaskBits; b++) begin
                    if ($urandom_range(0, flip_odds - 1) == 0) held_mask[b] = ~held_mask[b];
                end
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                clock_ms = $urandom;
            end else if (r < 10) begin
                clock_ms = clock_ms;
            end else if (r < 14) begin
                clock_ms = clock_ms + step_max * $urandom_range(2, 20);
            end else begin
                clock_ms = clock_ms + $urandom_range(1, step_max);
            end
            send_scan(held_mask, clock_ms);
            if (i == pause_at) wait_drained();
        end
    endtask

    // Reset values: press, long press, first and later repeats, release, bounce.
    task automatic test_default_timing();
        send_scan(4'h0, 32'd0);
        send_scan(4'hF, 32'd10);
        send_scan(4'hF, 32'd34);
        send_scan(4'hF, 32'd35);
        send_scan(4'hF, 32'd734);
        send_scan(4'hF, 32'd735);
        send_scan(4'hF, 32'd935);
        send_scan(4'hF, 32'd1110);
        send_scan(4'hF, 32'd2000);
        send_scan(4'h0, 32'd2010);
        send_scan(4'h0, 32'd2035);
        send_scan(4'h1, 32'd3000);
        send_scan(4'h0, 32'd3010);
        send_scan(4'h1, 32'd3020);
        send_scan(4'h1, 32'd3044);
        send_scan(4'h1, 32'd3045);
    endtask

    // All timing at zero: ten events in one scan, repeats on held scans.
    task automatic test_zero_timing();
        wait_drained();
        load_timing(16'd0, 16'd0, 16'd0, 16'd0);
        send_scan(4'hF, 32'hFFFF_FFFF);
        send_scan(4'hF, 32'h0000_0000);
        send_scan(4'h0, 32'h0000_0001);
        send_scan(4'h5, 32'h0000_0001);
        send_scan(4'hA, 32'h8000_0000);
        send_scan(4'h0, 32'h8000_0001);
    endtask

    // Press just before the timestamp wraps; the first repeat falls after it.
    task automatic test_time_wrap();
        wait_drained();
        load_timing(16'd2, 16'd5, 16'd10, 16'hFFFF);
        send_scan(4'h2, 32'hFFFF_FFF6);
        send_scan(4'h2, 32'hFFFF_FFF8);
        send_scan(4'h2, 32'hFFFF_FFFD);
        send_scan(4'h2, 32'h0000_0001);
        send_scan(4'h2, 32'h0000_0002);
        send_scan(4'h2, 32'h0000_0003);
        send_scan(4'h2, 32'h0001_0001);
        send_scan(4'h0, 32'h0001_0010);
    endtask

    task automatic test_random_small_timing();
        wait_drained();
        load_timing(16'd3, 16'd20, 16'd30, 16'd5);
        clock_ms = 32'd100;
        run_random_scans(120, 8, 10, -1);
    endtask

    task automatic test_random_default_timing();
        wait_drained();
        load_timing(bde_pkg::DebounceReset, bde_pkg::LongPressReset,
                    bde_pkg::RepeatDlyReset, bde_pkg::RepeatPerReset);
        run_random_scans(90, 100, 20, -1);
    endtask

    task automatic test_random_max_timing();
        wait_drained();
        load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        stall_enable = 1'b0;
        run_random_scans(70, 20000, 8, -1);
        stall_enable = 1'b1;
    endtask

    task automatic test_random_zero_timing();
        wait_drained();
        load_timing(16'd0, 16'd0, 16'd0, 16'd0);
        run_random_scans(60, 3, 4, 30);
    endtask

    task automatic test_random_mixed_wrap();
        wait_drained();
        load_timing(bde_pkg::CfgW'($urandom_range(0, 10)), bde_pkg::CfgW'($urandom_range(0, 40)),
                    bde_pkg::CfgW'($urandom_range(0, 60)), bde_pkg::CfgW'($urandom_range(0, 15)));
        clock_ms = 32'hFFFF_FC00;
        run_random_scans(120, 10, 12, -1);
    endtask

    initial begin
        deb_time_cfg   = bde_pkg::DebounceReset;
        long_time_cfg  = bde_pkg::LongPressReset;
        rpt_delay_cfg  = bde_pkg::RepeatDlyReset;
        rpt_period_cfg = bde_pkg::RepeatPerReset;
        for (int b = 0; b < NumButtons; b++) begin
            btn_raw[b]    = 1'b0;
            btn_stable[b] = 1'b0;
            btn_long[b]   = 1'b0;
            t_change[b]   = '0;
            t_press[b]    = '0;
            t_repeat[b]   = '0;
        end
        held_mask = '0;
        clock_ms  = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_timing();
        test_zero_timing();
        test_time_wrap();
        test_random_small_timing();
        test_random_default_timing();
        test_random_max_timing();
        test_random_zero_timing();
        test_random_mixed_wrap();

        wait_drained();
        if (pending_events.size() > 0) begin
            log_failure($sformatf("%0d expected events never arrived", pending_events.size()));
        end
        $display("Sent %0d scans, checked %0d events across %0d timing settings",
                 scans_sent, events_seen, settings_loaded);
        $display("Settings spanned zero, reset, small, random and maximum timing, with wrap");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/bde_pkg.sv
design/bde_front.sv
design/bde_fifo.sv
design/bde_back.sv
design/button_debounce_event_gen_unit.sv
verif/button_debounce_event_gen_unit_test.sv
